@@ rtl/kwm_pkg.sv @@
// kwm_pkg: shared widths, codes, types and the address helper of the k-way merge
// used by every file of the k_way_sorted_merge block; depends on nothing
package kwm_pkg;

    // field widths of the transfers
    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 2;

    // list geometry
    localparam int LISTS      = 8;
    localparam int LIST_DEPTH = 64;
    localparam int LIST_W     = $clog2(LISTS);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int MEM_WORDS  = LISTS * LIST_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_WORDS);

    // min tree geometry: one registered level per bit of the list index
    localparam int TREE_LEVELS = LIST_W;
    localparam int TREE_PAD    = 1 << LIST_W;
    localparam int TCNT_W      = $clog2(TREE_LEVELS) + 1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word [LISTS-1:0]        t_heads;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic [LIST_W-1:0]        t_list;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ADDR_W-1:0]        t_addr;

    // operation codes
    localparam t_op OP_APPEND = 2'd0;
    localparam t_op OP_TAKE   = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_ADVANCE,
        S_REFILL,
        S_RESULT
    } t_state;

    // one node of the min tree
    typedef struct packed {
        logic  live;
        t_list idx;
        t_word value;
    } t_min_res;

    // commands from the sequencer to the element store
    typedef struct packed {
        logic  mem_we;
        t_addr waddr;
        t_word wdata;
        logic  mem_re;
        t_addr raddr;
        logic  head_set;
        logic  head_fill;
        t_list head_sel;
    } t_store_cmd;

    // word address of a slot of a list
    function automatic t_addr slot_addr(input t_list list, input t_cnt slot);
        slot_addr = ADDR_W'(list) * ADDR_W'(LIST_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage

@@ rtl/kwm_in_if.sv @@
// kwm_in_if: valid/ready channel that carries one merge command
// depends on kwm_pkg
interface kwm_in_if;
    import kwm_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    logic [IDX_W-1:0] list_index;
    t_word value;

    modport source (output valid, output operation, output list_index, output value,
                    input ready);
    modport sink (input valid, input operation, input list_index, input value,
                  output ready);
endinterface

@@ rtl/kwm_out_if.sv @@
// kwm_out_if: valid/ready channel that carries one merge result
// depends on kwm_pkg
interface kwm_out_if;
    import kwm_pkg::*;

    logic    valid;
    logic    ready;
    t_word   merged_value;
    t_status status;

    modport source (output valid, output merged_value, output status, input ready);
    modport sink (input valid, input merged_value, input status, output ready);
endinterface

@@ rtl/kwm_store.sv @@
// kwm_store: shared element memory with registered read, plus the
// head register of every list; depends on kwm_pkg
module kwm_store (
    input  logic               i_clk,
    input  kwm_pkg::t_store_cmd i_cmd,
    output kwm_pkg::t_heads    o_heads
);
    import kwm_pkg::*;

    t_word r_mem [MEM_WORDS];
    t_word r_rd;
    t_heads r_heads;

    // element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.mem_re) begin
            r_rd <= r_mem[i_cmd.raddr];
        end
    end

    // head registers: direct load on append to an empty list, refill from memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.head_set) begin
            r_heads[i_cmd.head_sel] <= i_cmd.wdata;
        end else if (i_cmd.head_fill) begin
            r_heads[i_cmd.head_sel] <= r_rd;
        end
    end

    assign o_heads = r_heads;

endmodule

@@ rtl/kwm_min_tree.sv @@
// kwm_min_tree: registered binary tree that finds the smallest live head,
// lowest list index on ties; depends on kwm_pkg
module kwm_min_tree (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kwm_pkg::t_heads            i_heads,
    input  logic [kwm_pkg::LISTS-1:0]  i_live,
    output kwm_pkg::t_min_res          o_min
);
    import kwm_pkg::*;

    t_min_res w_leaf [TREE_PAD];
    t_min_res r_node [TREE_PAD-1];

    // right side wins only when strictly smaller
    function automatic t_min_res pick(input t_min_res a, input t_min_res b);
        if (b.live && (!a.live || (b.value < a.value))) begin
            pick = b;
        end else begin
            pick = a;
        end
    endfunction

    // leaves from the head registers, padding leaves never live
    for (genvar j = 0; j < TREE_PAD; j++) begin : g_leaf
        if (j < LISTS) begin : g_used
            assign w_leaf[j] = '{live: i_live[j], idx: LIST_W'(j), value: i_heads[j]};
        end else begin : g_pad
            assign w_leaf[j] = '0;
        end
    end

    // internal nodes, one register per node; node n has children 2n+1 and 2n+2
    for (genvar n = 0; n < TREE_PAD - 1; n++) begin : g_node
        t_min_res w_pick;
        if (2 * n + 1 >= TREE_PAD - 1) begin : g_from_leaf
            assign w_pick = pick(w_leaf[2 * n + 1 - (TREE_PAD - 1)],
                                 w_leaf[2 * n + 2 - (TREE_PAD - 1)]);
        end else begin : g_from_node
            assign w_pick = pick(r_node[2 * n + 1], r_node[2 * n + 2]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_node[n] <= '0;
            end else begin
                r_node[n] <= w_pick;
            end
        end
    end

    assign o_min = r_node[0];

endmodule

@@ rtl/k_way_sorted_merge.sv @@
// k_way_sorted_merge: top level; sequencer, per-list counters and result register
// depends on kwm_pkg, kwm_in_if, kwm_out_if, kwm_store, kwm_min_tree
//
// Keeps LISTS lists of signed 32-bit words in one shared memory of
// LISTS*LIST_DEPTH words. An append writes the next slot of a list (status
// full when the list already holds LIST_DEPTH words or the index is past the
// last list); a take returns the smallest current head over all non-empty lists
// and advances that list (status empty when none holds data); a clear empties
// all lists at once. Every command gives one result. One command is in work at
// a time: append, clear and the unused code pass from acceptance through the
// execute state to the result state, which loads the output register, and the
// next command is accepted in the idle state that follows; a take passes from
// execute through the search of the registered min tree over the head
// registers, the advance of the chosen list and the registered memory read
// that refills its head. A take skips the refill when that list becomes empty
// and skips both the advance and the refill when nothing is found.
// The output register lets the next command be accepted while a result waits;
// a result that finds the output register still full waits for the receiver.
// No clearing pass runs after reset: the memory is read only below a list's
// fill count.
module k_way_sorted_merge (
    input  logic   i_clk,
    input  logic   i_rst_n,
    kwm_in_if.sink   i_in,
    kwm_out_if.source o_out
);
    import kwm_pkg::*;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    logic    r_idx_ok, n_idx_ok;
    t_list   r_sel, n_sel;
    t_word   r_value, n_value;
    logic [TCNT_W-1:0] r_cnt, n_cnt;
    t_cnt    r_wc [LISTS];
    t_cnt    n_wc [LISTS];
    t_cnt    r_rp [LISTS];
    t_cnt    n_rp [LISTS];
    t_word   r_res_value, n_res_value;
    t_status r_res_status, n_res_status;
    logic    r_out_valid, n_out_valid;
    t_word   r_out_value, n_out_value;
    t_status r_out_status, n_out_status;

    t_store_cmd w_cmd;
    t_heads     w_heads;
    t_min_res   w_min;
    logic [LISTS-1:0] w_live;
    t_cnt       w_wc_sel;
    t_cnt       w_rp_sel;
    t_cnt       w_rp_next;

    kwm_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .o_heads (w_heads)
    );

    kwm_min_tree u_min_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_heads (w_heads),
        .i_live  (w_live),
        .o_min   (w_min)
    );

    // a list holds unread data while its read position trails its fill count
    always_comb begin
        for (int l = 0; l < LISTS; l++) begin
            w_live[l] = (r_rp[l] != r_wc[l]);
        end
    end

    assign w_wc_sel  = r_wc[r_sel];
    assign w_rp_sel  = r_rp[r_sel];
    assign w_rp_next = w_rp_sel + CNT_W'(1);

    // sequencer: next state, counter updates and store commands
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx_ok     = r_idx_ok;
        n_sel        = r_sel;
        n_value      = r_value;
        n_cnt        = r_cnt;
        n_wc         = r_wc;
        n_rp         = r_rp;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        w_cmd        = '0;
        w_cmd.head_sel = r_sel;
        w_cmd.wdata    = r_value;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op     = i_in.operation;
                    n_value  = i_in.value;
                    n_idx_ok = (32'(i_in.list_index) < 32'(LISTS));
                    n_sel    = LIST_W'(i_in.list_index);
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_state      = S_RESULT;
                case (r_op)
                    OP_APPEND: begin
                        if (r_idx_ok && (w_wc_sel < CNT_W'(LIST_DEPTH))) begin
                            w_cmd.mem_we   = 1'b1;
                            w_cmd.waddr    = slot_addr(r_sel, w_wc_sel);
                            w_cmd.head_set = (w_rp_sel == w_wc_sel);
                            n_wc[r_sel]    = w_wc_sel + CNT_W'(1);
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end
                    OP_TAKE: begin
                        n_cnt   = '0;
                        n_state = S_SEARCH;
                    end
                    OP_CLEAR: begin
                        for (int l = 0; l < LISTS; l++) begin
                            n_wc[l] = '0;
                            n_rp[l] = '0;
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_SEARCH: begin
                if (r_cnt == TCNT_W'(TREE_LEVELS - 1)) begin
                    if (w_min.live) begin
                        n_sel        = w_min.idx;
                        n_res_value  = w_min.value;
                        n_res_status = ST_OK;
                        n_state      = S_ADVANCE;
                    end else begin
                        n_res_value  = '0;
                        n_res_status = ST_EMPTY;
                        n_state      = S_RESULT;
                    end
                end else begin
                    n_cnt = r_cnt + TCNT_W'(1);
                end
            end
            S_ADVANCE: begin
                n_rp[r_sel] = w_rp_next;
                if (w_rp_next < w_wc_sel) begin
                    w_cmd.mem_re = 1'b1;
                    w_cmd.raddr  = slot_addr(r_sel, w_rp_next);
                    n_state      = S_REFILL;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_REFILL: begin
                w_cmd.head_fill = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LISTS; l++) begin
                r_wc[l] <= '0;
                r_rp[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_wc        <= n_wc;
            r_rp        <= n_rp;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx_ok     <= n_idx_ok;
        r_sel        <= n_sel;
        r_value      <= n_value;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.merged_value = r_out_value;
    assign o_out.status       = r_out_status;

`ifndef SYNTHESIS
    // a transfer in always starts command execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_EXEC))
        else $error("accepted command did not start execution");

    // the list chosen by a take still holds unread data
    a_advance_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADVANCE) |-> (w_rp_sel != w_wc_sel))
        else $error("take advanced an empty list");

    // the selected list's fill count never passes the list depth while a command is in work
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (w_wc_sel <= CNT_W'(LIST_DEPTH)))
        else $error("list fill count past depth");

    // a result appears only after the result state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESULT))
        else $error("result loaded outside result state");
`endif

endmodule

@@ tb/tb_k_way_sorted_merge.sv @@
// tb_k_way_sorted_merge: self-checking testbench of the k-way sorted merge
// depends on kwm_pkg, kwm_in_if, kwm_out_if and k_way_sorted_merge
// drives append, take, clear and unused-code commands, predicts each result and checks it in order
module tb_k_way_sorted_merge;
    import kwm_pkg::*;

    localparam t_op   OP_UNUSED   = 2'd3;
    localparam t_word WORD_MIN    = 32'sh8000_0000;
    localparam t_word WORD_MAX    = 32'sh7FFF_FFFF;
    localparam int    QUIET_LIMIT = 4000;
    localparam int    PHASE_ITEMS = 170;

    typedef struct {
        t_word   value;
        t_status status;
    } t_merge_result;

    // predictor of the list store plus the queue of results still owed by the block
    class merge_checker;
        t_word         slots [LISTS][LIST_DEPTH];
        int            fill [LISTS];
        int            taken [LISTS];
        t_merge_result pending [$];
        int            mismatches;

        function new();
            mismatches = 0;
            foreach (fill[l]) begin
                fill[l]  = 0;
                taken[l] = 0;
            end
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        // work out the result of one accepted command and update the lists
        function void note_command(input t_op op, input logic [IDX_W-1:0] idx,
                                   input t_word val);
            t_merge_result res;
            bit            found;
            int            best;
            t_word         best_val;
            res.value  = '0;
            res.status = ST_OK;
            case (op)
                OP_APPEND: begin
                    if (idx >= LISTS || fill[idx] >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        slots[idx][fill[idx]] = val;
                        fill[idx]++;
                    end
                end
                OP_TAKE: begin
                    found    = 1'b0;
                    best     = 0;
                    best_val = '0;
                    // lowest index wins on equal heads
                    for (int l = 0; l < LISTS; l++) begin
                        if (taken[l] < fill[l] && (!found || slots[l][taken[l]] < best_val)) begin
                            found    = 1'b1;
                            best     = l;
                            best_val = slots[l][taken[l]];
                        end
                    end
                    if (found) begin
                        taken[best]++;
                        res.value = best_val;
                    end else begin
                        res.status = ST_EMPTY;
                    end
                end
                OP_CLEAR: begin
                    foreach (fill[l]) begin
                        fill[l]  = 0;
                        taken[l] = 0;
                    end
                end
                default: ;
            endcase
            pending.insert(pending.size(), res);
        endfunction

        // compare one result transfer with the oldest expectation
        task check_result(input t_word value, input t_status status);
            t_merge_result exp_res;
            if (pending.size() == 0) begin
                report($sformatf("result value %0d status %0d with nothing expected",
                                 value, status));
            end else begin
                exp_res = pending.pop_front();
                if (value !== exp_res.value)
                    report($sformatf("merged_value %0d, expected %0d", value, exp_res.value));
                if (status !== exp_res.status)
                    report($sformatf("status %0d, expected %0d", status, exp_res.status));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    kwm_in_if  cmd_if ();
    kwm_out_if res_if ();

    k_way_sorted_merge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if.sink),
        .o_out   (res_if.source)
    );

    merge_checker sb;
    int           sender_idle_pct    = 0;
    int           receiver_stall_pct = 0;
    int           commands_sent      = 0;
    int           quiet_cycles       = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result sink with random stalls
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // monitor: check result transfers, record command transfers, count quiet cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.merged_value, res_if.status);
            if (cmd_if.valid && cmd_if.ready)
                sb.note_command(cmd_if.operation, cmd_if.list_index, cmd_if.value);
            if ((res_if.valid && res_if.ready) || (cmd_if.valid && cmd_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transfer in %0d cycles", QUIET_LIMIT);
        $display("k_way_sorted_merge regression: fail");
        $finish;
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send_command(input t_op op, input logic [IDX_W-1:0] idx, input t_word val);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.operation  <= op;
        cmd_if.list_index <= idx;
        cmd_if.value      <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        if (op != OP_UNUSED)
            commands_sent++;
    endtask

    // hold off commands until every owed result has come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // element values: extremes, a narrow band that gives equal heads, and wide random
    function automatic t_word pick_value();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return -1;
            3, 4:    return t_word'(int'($urandom_range(0, 16)) - 8);
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_list();
        return IDX_W'($urandom_range(0, LISTS - 1));
    endfunction

    // random traffic: bursts of appends and takes, occasional clears, fills and noise
    task automatic run_phase(input int items);
        int start;
        int len;
        bit filled;
        logic [IDX_W-1:0] target;
        start  = commands_sent;
        filled = 1'b0;
        while (commands_sent - start < items) begin
            len = $urandom_range(0, 99);
            if (!filled && (len >= 94 || commands_sent - start >= items / 2)) begin
                // push one list past its depth
                filled = 1'b1;
                target = pick_list();
                repeat (LIST_DEPTH + 2) send_command(OP_APPEND, target, pick_value());
            end else if (len < 40) begin
                repeat ($urandom_range(1, 12)) send_command(OP_APPEND, pick_list(), pick_value());
            end else if (len < 72) begin
                repeat ($urandom_range(1, 10)) send_command(OP_TAKE, pick_list(), pick_value());
            end else if (len < 86) begin
                repeat ($urandom_range(1, 15)) begin
                    if ($urandom_range(0, 1))
                        send_command(OP_APPEND, pick_list(), pick_value());
                    else
                        send_command(OP_TAKE, pick_list(), t_word'($urandom));
                end
            end else if (len < 90) begin
                send_command(OP_CLEAR, pick_list(), t_word'($urandom));
            end else begin
                // noise: unused code or stray fields on any command
                send_command(t_op'($urandom_range(0, 3)), pick_list(), t_word'($urandom));
            end
        end
    endtask

    // main sequence
    initial begin
        int sender_plan [4];
        int receiver_plan [4];
        sender_plan   = '{0, 61, 0, 15};
        receiver_plan = '{0, 0, 61, 15};
        sb = new();
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.operation  <= OP_APPEND;
        cmd_if.list_index <= '0;
        cmd_if.value      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty take after reset, one value on every list including the extremes, equal heads
        send_command(OP_TAKE, 3'd0, '0);
        send_command(OP_APPEND, 3'd0, WORD_MIN);
        send_command(OP_APPEND, 3'd7, WORD_MAX);
        send_command(OP_APPEND, 3'd3, 32'sd0);
        send_command(OP_APPEND, 3'd5, -32'sd1);
        send_command(OP_APPEND, 3'd1, 32'sd5);
        send_command(OP_APPEND, 3'd2, 32'sd5);
        send_command(OP_APPEND, 3'd6, 32'sh5555_5555);
        send_command(OP_APPEND, 3'd4, 32'shAAAA_AAAA);
        repeat (9) send_command(OP_TAKE, 3'd7, '1);
        // unused code, then clear drops a pending element
        send_command(OP_UNUSED, 3'd7, '1);
        send_command(OP_APPEND, 3'd2, 32'sd1);
        send_command(OP_CLEAR, 3'd5, '1);
        send_command(OP_TAKE, 3'd0, '0);

        // random phases with different idle and stall mixes
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = sender_plan[p];
            receiver_stall_pct = receiver_plan[p];
            run_phase(PHASE_ITEMS);
            if (p == 1)
                wait_drained();
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        if (sb.mismatches == 0)
            $display("k_way_sorted_merge regression: pass");
        else
            $display("k_way_sorted_merge regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/kwm_pkg.sv
rtl/kwm_in_if.sv
rtl/kwm_out_if.sv
rtl/kwm_store.sv
rtl/kwm_min_tree.sv
rtl/k_way_sorted_merge.sv
tb/tb_k_way_sorted_merge.sv
